// File: design/gbc_pkg.sv
package gbc_pkg;

	// Field and register widths
	localparam int RATE_W   = 16;
	localparam int OFS_W    = 15;
	localparam int LIM_W    = 8;
	localparam int TIME_W   = 32;
	localparam int NUM_AXES = 3;

	// Averaging window
	localparam int SAMPLE_COUNT = 2000;
	localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);

	// Accumulator and divider widths
	localparam int SUM_W       = 28;
	localparam int MAG_W       = SUM_W - 1;
	localparam int RECIP_SHIFT = MAG_W;
	localparam int RECIP       = (2 ** RECIP_SHIFT) / SAMPLE_COUNT;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int Q_W         = $clog2((2 ** MAG_W) / SAMPLE_COUNT + 1);
	localparam int PROD_W      = MAG_W + RECIP_W;
	localparam int QD_W        = Q_W + CNT_W;

	// Output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int FLY_W      = 3;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_OFFSET,
		REG_OUTLIER_LIMIT,
		REG_TIMEOUT_MS
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_RUNNING,
		ST_READY,
		ST_RANGE,
		ST_TIMEOUT
	} status_t;

	typedef struct packed {
		logic clr;
		logic add;
	} lane_ctl_t;

	typedef struct packed {
		logic                     bad;
		logic signed [RATE_W-1:0] avg;
	} lane_res_t;

	typedef struct packed {
		status_t                  status;
		logic signed [RATE_W-1:0] bias_p;
		logic signed [RATE_W-1:0] bias_q;
		logic signed [RATE_W-1:0] bias_r;
	} res_t;

endpackage

// File: design/gbc_in_if.sv
interface gbc_in_if import gbc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] rate_p;
	logic signed [RATE_W-1:0] rate_q;
	logic signed [RATE_W-1:0] rate_r;
	logic [TIME_W-1:0]        time_ms;

	modport source (output valid, rate_p, rate_q, rate_r, time_ms, input ready);
	modport sink   (input valid, rate_p, rate_q, rate_r, time_ms, output ready);
endinterface

// File: design/gbc_out_if.sv
interface gbc_out_if import gbc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [RATE_W-1:0] bias_p;
	logic signed [RATE_W-1:0] bias_q;
	logic signed [RATE_W-1:0] bias_r;

	modport source (output valid, status, bias_p, bias_q, bias_r, input ready);
	modport sink   (input valid, status, bias_p, bias_q, bias_r, output ready);
endinterface

// File: design/gbc_cfg_if.sv
interface gbc_cfg_if import gbc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: design/gyro_bias_calibrator.sv
// Path from sample beat to result beat: 4 lane stages, then the result queue.
// Throughput: one sample per cycle; input ready drops only when the 8-entry result
// queue plus the up to 4 beats in flight would be full, i.e. only under output back-pressure.
// Reset (arst_n low, async): registers back to 200 / 3 / 20000, sums, quiet count and
// outlier run cleared, pipeline and result queue emptied.
module gyro_bias_calibrator import gbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gbc_in_if.sink     smp,
	gbc_out_if.source  res,
	gbc_cfg_if.sink    cfg
);

	// Configuration registers
	logic [OFS_W-1:0]  max_offset_q;
	logic [LIM_W-1:0]  outlier_limit_q;
	logic [TIME_W-1:0] timeout_ms_q;

	// Lane plumbing
	logic signed [RATE_W-1:0] rate_in [NUM_AXES];
	logic [NUM_AXES-1:0]      over;
	lane_res_t                lane_res [NUM_AXES];
	lane_ctl_t                ctl;

	// Queue plumbing
	logic               acc;
	logic               wr_en;
	res_t               wr_data;
	res_t               rd_data;
	logic               not_empty;
	logic [FIFO_CW-1:0] q_count;
	logic [FLY_W-1:0]   inflight;

	// Config writes are always taken; an index past the list is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_offset_q    <= OFS_W'(200);
			outlier_limit_q <= LIM_W'(3);
			timeout_ms_q    <= TIME_W'(20000);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_OFFSET:    max_offset_q    <= cfg.data[OFS_W-1:0];
				REG_OUTLIER_LIMIT: outlier_limit_q <= cfg.data[LIM_W-1:0];
				REG_TIMEOUT_MS:    timeout_ms_q    <= cfg.data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Credit check: every accepted beat has a queue slot reserved, so the
	// pipeline itself never stalls.
	assign smp.ready = ({1'b0, q_count} + (FIFO_CW + 1)'(inflight)) < (FIFO_CW + 1)'(FIFO_DEPTH);
	assign acc       = smp.valid && smp.ready;

	assign rate_in[0] = smp.rate_p;
	assign rate_in[1] = smp.rate_q;
	assign rate_in[2] = smp.rate_r;

	// One lane per axis: magnitude test, accumulator and the divide-by-N pipe.
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
		gbc_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.rate       (rate_in[a]),
			.max_offset (max_offset_q),
			.ctl        (ctl),
			.over       (over[a]),
			.res        (lane_res[a])
		);
	end

	// Outlier/quiet decision feeding the lanes, and the merge of lane results
	gbc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.time_ms       (smp.time_ms),
		.timeout_ms    (timeout_ms_q),
		.outlier_limit (outlier_limit_q),
		.over          (over),
		.lane_res      (lane_res),
		.ctl           (ctl),
		.wr_en         (wr_en),
		.wr_data       (wr_data),
		.inflight      (inflight)
	);

	// Result queue decouples the output from the sample side
	gbc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.rd_en     (not_empty && res.ready),
		.rd_data   (rd_data),
		.not_empty (not_empty),
		.count     (q_count)
	);

	assign res.valid  = not_empty;
	assign res.status = rd_data.status;
	assign res.bias_p = rd_data.bias_p;
	assign res.bias_q = rd_data.bias_q;
	assign res.bias_r = rd_data.bias_r;

endmodule

// File: design/gbc_lane.sv
module gbc_lane import gbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [RATE_W-1:0] rate,
	input  logic [OFS_W-1:0]         max_offset,
	input  lane_ctl_t                ctl,
	output logic                     over,
	output lane_res_t                res
);

	logic signed [RATE_W:0]  rate_x;
	logic [RATE_W:0]         rate_mag;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [SUM_W-1:0]        sum_abs;
	logic [PROD_W-1:0]       prod;
	logic [MAG_W-1:0]        rem;

	logic [MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic             neg_s1, neg_s2, neg_s3, neg_s4;
	logic [Q_W-1:0]   q0_s2, q0_s3, q_s4;
	logic [QD_W-1:0]  qd_s3;

	// magnitude test; -32768 gives 32768 and is always over
	assign rate_x   = {rate[RATE_W-1], rate};
	assign rate_mag = rate[RATE_W-1] ? unsigned'(-rate_x) : unsigned'(rate_x);
	assign over     = rate_mag > {2'b00, max_offset};

	always_comb begin
		if (ctl.clr) begin
			sum_nxt = '0;
		end else if (ctl.add) begin
			sum_nxt = sum_q + SUM_W'(rate);
		end else begin
			sum_nxt = sum_q;
		end
	end

	assign sum_abs = sum_nxt[SUM_W-1] ? unsigned'(-sum_nxt) : unsigned'(sum_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else begin
			sum_q <= sum_nxt;
		end
	end

	// divide by reciprocal, then one compare-and-increment fix
	assign prod = PROD_W'(mag_s1) * PROD_W'(RECIP);
	assign rem  = mag_s3 - qd_s3[MAG_W-1:0];

	always_ff @(posedge clk) begin
		mag_s1 <= sum_abs[MAG_W-1:0];
		neg_s1 <= sum_nxt[SUM_W-1];

		q0_s2  <= prod[RECIP_SHIFT +: Q_W];
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;

		qd_s3  <= QD_W'(q0_s2) * QD_W'(SAMPLE_COUNT);
		q0_s3  <= q0_s2;
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;

		q_s4   <= (rem >= MAG_W'(SAMPLE_COUNT)) ? q0_s3 + Q_W'(1) : q0_s3;
		neg_s4 <= neg_s3;
	end

	assign res.bad = q_s4 > Q_W'(max_offset);
	assign res.avg = neg_s4 ? -signed'(q_s4[RATE_W-1:0]) : signed'(q_s4[RATE_W-1:0]);

endmodule

// File: design/gbc_ctrl.sv
module gbc_ctrl import gbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  logic [TIME_W-1:0]     time_ms,
	input  logic [TIME_W-1:0]     timeout_ms,
	input  logic [LIM_W-1:0]      outlier_limit,
	input  logic [NUM_AXES-1:0]   over,
	input  lane_res_t             lane_res [NUM_AXES],
	output lane_ctl_t             ctl,
	output logic                  wr_en,
	output res_t                  wr_data,
	output logic [FLY_W-1:0]      inflight
);

	logic [CNT_W-1:0] quiet_count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [LIM_W-1:0] outlier_run_q;
	logic [LIM_W-1:0] run_inc;
	logic             running;
	logic             outlier;
	logic             bad;

	logic v_s1, v_s2, v_s3, v_s4;
	logic done_s1, done_s2, done_s3, done_s4;
	logic tmo_s1, tmo_s2, tmo_s3, tmo_s4;

	assign running = quiet_count_q != CNT_W'(SAMPLE_COUNT);
	assign outlier = |over;
	assign run_inc = (outlier_run_q == '1) ? outlier_run_q : outlier_run_q + LIM_W'(1);

	assign ctl.clr = acc && running && outlier && (run_inc > outlier_limit);
	assign ctl.add = acc && running && !outlier;

	always_comb begin
		if (ctl.clr) begin
			count_nxt = '0;
		end else if (ctl.add) begin
			count_nxt = quiet_count_q + CNT_W'(1);
		end else begin
			count_nxt = quiet_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_count_q <= '0;
			outlier_run_q <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
		end else begin
			quiet_count_q <= count_nxt;
			if (acc && running) begin
				outlier_run_q <= outlier ? run_inc : '0;
			end
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		done_s1 <= count_nxt == CNT_W'(SAMPLE_COUNT);
		tmo_s1  <= time_ms > timeout_ms;
		done_s2 <= done_s1;
		tmo_s2  <= tmo_s1;
		done_s3 <= done_s2;
		tmo_s3  <= tmo_s2;
		done_s4 <= done_s3;
		tmo_s4  <= tmo_s3;
	end

	assign inflight = FLY_W'(v_s1) + FLY_W'(v_s2) + FLY_W'(v_s3) + FLY_W'(v_s4);

	// merge: any axis out of range spoils the whole bias
	assign bad = lane_res[0].bad || lane_res[1].bad || lane_res[2].bad;

	always_comb begin
		wr_data.bias_p = '0;
		wr_data.bias_q = '0;
		wr_data.bias_r = '0;
		priority if (done_s4 && !bad) begin
			wr_data.status = ST_READY;
			wr_data.bias_p = lane_res[0].avg;
			wr_data.bias_q = lane_res[1].avg;
			wr_data.bias_r = lane_res[2].avg;
		end else if (done_s4) begin
			wr_data.status = ST_RANGE;
		end else if (tmo_s4) begin
			wr_data.status = ST_TIMEOUT;
		end else begin
			wr_data.status = ST_RUNNING;
		end
	end

	assign wr_en = v_s4;

endmodule

// File: design/gbc_fifo.sv
module gbc_fifo import gbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  res_t               wr_data,
	input  logic               rd_en,
	output res_t               rd_data,
	output logic               not_empty,
	output logic [FIFO_CW-1:0] count
);

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(wr_en) - FIFO_CW'(rd_en);
		end
	end

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

// File: tb/gyro_bias_calibrator_test.sv
`timescale 1ns / 100ps

module gyro_bias_calibrator_test;
	import gbc_pkg::*;

	// Index with no register behind it; writes to it must leave all settings alone
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam logic signed [RATE_W-1:0] RATE_MIN = 16'sh8000;
	localparam logic signed [RATE_W-1:0] RATE_MAX = 16'sh7fff;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	gbc_in_if  smp();
	gbc_out_if res();
	gbc_cfg_if cfg();

	gyro_bias_calibrator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	// Shadow of the calibration state and the register file
	logic signed [SUM_W-1:0] axis_sum [NUM_AXES];
	logic [CNT_W-1:0]        quiet_cnt;
	logic [LIM_W-1:0]        outlier_run;
	logic [OFS_W-1:0]        max_ofs;
	logic [LIM_W-1:0]        out_lim;
	logic [TIME_W-1:0]       tmo_ms;

	// Reports owed by the block, oldest first
	res_t calib_reports_q [$];
	int   n_mismatch = 0;

	// Sender burst state and receiver stall pattern
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int rx_cycle   = 0;

	// Advance the shadow state by one sample and return the report it yields
	function automatic res_t predict_bias(input logic signed [RATE_W-1:0] p, q, r,
			input logic [TIME_W-1:0] now);
		int   rate [NUM_AXES];
		int   avg  [NUM_AXES];
		logic loud;
		logic off_range;
		res_t rpt;
		rate[0] = p;
		rate[1] = q;
		rate[2] = r;
		rpt = '{status: ST_RUNNING, bias_p: '0, bias_q: '0, bias_r: '0};
		// once the window is full, samples no longer touch the state
		if (quiet_cnt < SAMPLE_COUNT) begin
			loud = 1'b0;
			foreach (rate[i])
				if ((rate[i] < 0 ? -rate[i] : rate[i]) > int'(max_ofs))
					loud = 1'b1;
			if (loud) begin
				if (outlier_run != 8'hff)
					outlier_run++;
				// run is kept across a restart: each further outlier restarts again
				if (outlier_run > out_lim) begin
					quiet_cnt = '0;
					foreach (axis_sum[i])
						axis_sum[i] = '0;
				end
			end else begin
				outlier_run = '0;
				quiet_cnt++;
				foreach (axis_sum[i])
					axis_sum[i] = axis_sum[i] + rate[i];
			end
		end
		if (quiet_cnt == SAMPLE_COUNT) begin
			// signed division truncates toward zero; timeout no longer applies
			off_range = 1'b0;
			foreach (avg[i]) begin
				avg[i] = int'(axis_sum[i]) / SAMPLE_COUNT;
				if ((avg[i] < 0 ? -avg[i] : avg[i]) > int'(max_ofs))
					off_range = 1'b1;
			end
			if (off_range) begin
				rpt.status = ST_RANGE;
			end else begin
				rpt.status = ST_READY;
				rpt.bias_p = RATE_W'(avg[0]);
				rpt.bias_q = RATE_W'(avg[1]);
				rpt.bias_r = RATE_W'(avg[2]);
			end
		end else if (now > tmo_ms) begin
			rpt.status = ST_TIMEOUT;
		end
		return rpt;
	endfunction

	// Random rate within the current quiet band, edges favoured
	function automatic logic signed [RATE_W-1:0] rand_quiet_rate();
		int mag;
		mag = ($urandom_range(0, 3) == 0) ? int'(max_ofs) : $urandom_range(0, max_ofs);
		return $urandom_range(0, 1) ? RATE_W'(-mag) : RATE_W'(mag);
	endfunction

	// Random rate guaranteed outside the quiet band
	function automatic logic signed [RATE_W-1:0] rand_loud_rate();
		int mag;
		if (max_ofs == 15'h7fff || $urandom_range(0, 5) == 0)
			return RATE_MIN;
		mag = ($urandom_range(0, 2) == 0) ? int'(max_ofs) + 1
			: $urandom_range(int'(max_ofs) + 1, 32767);
		return $urandom_range(0, 1) ? RATE_W'(-mag) : RATE_W'(mag);
	endfunction

	// Timestamps clustered round the timeout boundary, plus the extremes
	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return tmo_ms;
			2: return tmo_ms + 1;
			3: return tmo_ms - 1;
			4: return '1;
			default: return $urandom;
		endcase
	endfunction

	// One sample beat. Entered and left at a falling edge; valid stays up
	// between back-to-back beats so it is never lowered and raised in one step.
	task automatic send_sample(input logic signed [RATE_W-1:0] p, q, r,
			input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				smp.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		smp.valid   <= 1'b1;
		smp.rate_p  <= p;
		smp.rate_q  <= q;
		smp.rate_r  <= r;
		smp.time_ms <= t;
		do @(posedge clk); while (!smp.ready);
		calib_reports_q.push_back(predict_bias(p, q, r, t));
		@(negedge clk);
	endtask

	task automatic send_quiet(input logic [TIME_W-1:0] t);
		send_sample(rand_quiet_rate(), rand_quiet_rate(), rand_quiet_rate(), t);
	endtask

	// One axis surely loud, the others anything
	task automatic send_loud(input logic [TIME_W-1:0] t);
		logic signed [RATE_W-1:0] v [NUM_AXES];
		int k;
		k = $urandom_range(0, NUM_AXES - 1);
		foreach (v[i])
			v[i] = (i == k) ? rand_loud_rate()
				: ($urandom_range(0, 1) ? rand_quiet_rate() : RATE_W'($urandom));
		send_sample(v[0], v[1], v[2], t);
	endtask

	task automatic send_junk();
		send_sample(RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom), rand_time());
	endtask

	// Drop valid and let every owed report drain
	task automatic wait_idle();
		smp.valid <= 1'b0;
		while (calib_reports_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_MAX_OFFSET:    max_ofs = data[OFS_W-1:0];
			REG_OUTLIER_LIMIT: out_lim = data[LIM_W-1:0];
			REG_TIMEOUT_MS:    tmo_ms  = data;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Junk in the unused upper bits checks the field masking
	task automatic set_config(input logic [OFS_W-1:0] ofs, input logic [LIM_W-1:0] lim,
			input logic [TIME_W-1:0] tmo);
		wait_idle();
		write_reg(REG_MAX_OFFSET, ($urandom & ~32'h7fff) | ofs);
		write_reg(REG_OUTLIER_LIMIT, ($urandom & ~32'hff) | lim);
		write_reg(REG_TIMEOUT_MS, tmo);
	endtask

	// Quiet runs broken by outlier bursts sized round the limit, with some noise
	task automatic run_mix(input int n_items);
		int sent;
		int run_len;
		bit loud_run;
		sent = 0;
		while (sent < n_items) begin
			loud_run = ($urandom_range(0, 2) == 0);
			run_len  = loud_run ? int'(out_lim) + int'($urandom_range(0, 3)) - 1
				: int'($urandom_range(1, 20));
			if (run_len < 1)
				run_len = 1;
			if (run_len > n_items - sent)
				run_len = n_items - sent;
			repeat (run_len) begin
				if ($urandom_range(0, 7) == 0)
					send_junk();
				else if (loud_run)
					send_loud(rand_time());
				else
					send_quiet(rand_time());
				sent++;
			end
		end
	endtask

	// Band edges at the reset setting of 200
	task automatic test_quiet_bounds();
		send_sample(16'sd200, -16'sd200, 16'sd200, 32'd0);
		send_sample(-16'sd200, 16'sd200, -16'sd200, 32'd0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
		send_sample(16'sd201, 16'sd0, 16'sd0, 32'd0);
		send_sample(16'sd1, -16'sd201, 16'sd0, 32'd0);
		send_sample(16'sd7, 16'sd9, -16'sd11, 32'd0);
	endtask

	// Runs of three outliers survive; the fourth and any after it restart
	task automatic test_outlier_restart();
		send_sample(RATE_MIN, 16'sd0, 16'sd0, 32'd100);
		send_sample(16'sd0, RATE_MAX, 16'sd0, 32'd100);
		send_sample(16'sd0, 16'sd0, RATE_MIN, 32'd100);
		send_sample(16'sd1, 16'sd1, 16'sd1, 32'd100);
		repeat (5)
			send_sample(RATE_MAX, RATE_MIN, RATE_MAX, 32'd100);
		send_sample(16'sd5, -16'sd5, 16'sd5, 32'd100);
	endtask

	// Equal to the timeout is still running; one past it times out
	task automatic test_timeout_boundary();
		send_sample(16'sd3, 16'sd3, 16'sd3, 32'd20000);
		send_sample(16'sd3, 16'sd3, 16'sd3, 32'd20001);
		send_sample(16'sd3, 16'sd3, 16'sd3, 32'hffff_ffff);
		send_sample(16'sd3, 16'sd3, 16'sd3, 32'd19999);
		send_sample(RATE_MIN, 16'sd3, 16'sd3, 32'hffff_ffff);
	endtask

	// Dead index, then both extremes of every register
	task automatic test_register_writes();
		wait_idle();
		write_reg(REG_UNUSED, 32'h0000_0001);
		send_sample(16'sd150, -16'sd150, 16'sd150, 32'd20001);
		set_config('0, '0, '0);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
		send_sample(16'sd1, 16'sd0, 16'sd0, 32'd1);
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd5);
		set_config(15'h7fff, 8'hff, 32'hffff_ffff);
		send_sample(RATE_MAX, -16'sd32767, RATE_MAX, 32'hffff_ffff);
		send_sample(RATE_MIN, 16'sd0, 16'sd0, 32'hffff_ffff);
	endtask

	// Run pinned at 255 with the limit at 255, then a lower limit below the pinned run
	task automatic test_outlier_saturation();
		set_config(15'd100, 8'hff, $urandom);
		repeat (270)
			send_loud(rand_time());
		set_config(15'd100, 8'd254, $urandom);
		repeat (5)
			send_loud(rand_time());
		run_mix(25);
	endtask

	task automatic test_random_traffic();
		set_config(15'd1, 8'd1, 32'd1000);
		run_mix(80);
		set_config('0, '0, '0);
		run_mix(60);
		set_config(15'd500, 8'd7, $urandom);
		run_mix(80);
		set_config(15'h7fff, 8'd2, 32'hffff_ffff);
		run_mix(80);
		set_config(OFS_W'($urandom), LIM_W'($urandom_range(0, 12)), $urandom);
		run_mix(80);
		set_config(15'd200, 8'd3, 32'd20000);
		run_mix(60);
	endtask

	// Fill the window (nothing resets the block afterwards, so this runs last),
	// then move the band across the frozen averages
	task automatic test_calibration_done();
		int peak;
		int a;
		// timeout 0: every unfinished beat with a nonzero time reports a timeout, the finished ones must not
		set_config(15'h7fff, 8'hff, '0);
		while (quiet_cnt < SAMPLE_COUNT) begin
			case ($urandom_range(0, 15))
				0: send_sample(RATE_MIN, RATE_W'($urandom), RATE_W'($urandom), $urandom);
				1: send_sample(RATE_MAX, -16'sd32767, RATE_MAX, 32'd0);
				default: send_sample(RATE_W'($urandom_range(0, 4000)),
					RATE_W'(-int'($urandom_range(0, 3000))),
					RATE_W'($urandom_range(0, 65534) - 32767), $urandom);
			endcase
		end
		repeat (10)
			send_junk();
		peak = 0;
		foreach (axis_sum[i]) begin
			a = int'(axis_sum[i]) / SAMPLE_COUNT;
			if (a < 0)
				a = -a;
			if (a > peak)
				peak = a;
		end
		set_config(OFS_W'(peak), LIM_W'($urandom), $urandom);
		repeat (6)
			send_junk();
		if (peak > 0) begin
			set_config(OFS_W'(peak - 1), '0, '0);
			repeat (6)
				send_junk();
		end
		set_config('0, 8'd3, 32'd20000);
		repeat (6)
			send_junk();
		set_config(15'h7fff, 8'hff, 32'hffff_ffff);
		repeat (6)
			send_junk();
	endtask

	// Receiver: pattern switches among always ready, coin toss, a fixed
	// three-in-four duty and long stalls
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= $urandom_range(0, 1);
			2: res.ready <= (rx_cycle % 4 != 3);
			default: res.ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Compare every report beat against the oldest owed report
	always @(posedge clk) begin : check_reports
		res_t want;
		if (arst_n && res.valid && res.ready) begin
			if (calib_reports_q.size() == 0) begin
				n_mismatch++;
				$display("%0t: report beat with none owed: status %0d bias %0d %0d %0d",
					$time, res.status, res.bias_p, res.bias_q, res.bias_r);
			end else begin
				want = calib_reports_q.pop_front();
				if (res.status !== want.status || res.bias_p !== want.bias_p ||
						res.bias_q !== want.bias_q || res.bias_r !== want.bias_r) begin
					n_mismatch++;
					$display("%0t: expected status %0d bias %0d %0d %0d, actual status %0d bias %0d %0d %0d",
						$time, want.status, want.bias_p, want.bias_q, want.bias_r,
						res.status, res.bias_p, res.bias_q, res.bias_r);
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		smp.valid   = 1'b0;
		smp.rate_p  = '0;
		smp.rate_q  = '0;
		smp.rate_r  = '0;
		smp.time_ms = '0;
		cfg.valid   = 1'b0;
		cfg.index   = '0;
		cfg.data    = '0;
		res.ready   = 1'b0;
		// shadow starts from the reset settings
		max_ofs     = 15'd200;
		out_lim     = 8'd3;
		tmo_ms      = 32'd20000;
		quiet_cnt   = '0;
		outlier_run = '0;
		foreach (axis_sum[i])
			axis_sum[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_quiet_bounds();
		test_outlier_restart();
		test_timeout_boundary();
		test_register_writes();
		test_outlier_saturation();
		test_random_traffic();
		test_calibration_done();

		wait_idle();
		// run on past the pipeline depth to catch stray beats
		repeat (20) @(posedge clk);
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
